// ===== src/cslog_pkg.sv =====
package cslog_pkg;

  localparam int unsigned LOG_DEPTH_DEF = 32;
  localparam int unsigned DUMP_MAX      = 32;
  localparam logic [5:0]  DUMP_LIMIT_RST = 6'd10;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 72;

  typedef enum logic [2:0] {
    MODE_RECORD = 3'd0,
    MODE_DUMP   = 3'd1,
    MODE_CLEAR  = 3'd2,
    MODE_TOGGLE = 3'd3,
    MODE_STATUS = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic [7:0]  sum;
    logic [7:0]  q;
    logic [15:0] v;
    logic [7:0]  id;
    logic [15:0] t;
  } log_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic do_record;
    logic do_clear;
    logic do_toggle;
    logic load_status;
    logic dump_start;
    logic dump_emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] mode;
    logic       dump_empty;
    logic       dump_last;
    logic       out_free;
  } sts_t;

  function automatic logic [7:0] byte_sum(logic [15:0] t, logic [7:0] id,
                                          logic [15:0] v, logic [7:0] q);
    byte_sum = t[15:8] + t[7:0] + id + v[15:8] + v[7:0] + q;
  endfunction

endpackage

// ===== src/cslog_ctrl.sv =====
module cslog_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  cslog_pkg::sts_t   sts,
  output cslog_pkg::cmd_t   cmd
);

  cslog_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cslog_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cslog_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = cslog_pkg::ST_EXEC;
        end
      end
      cslog_pkg::ST_EXEC: begin
        case (sts.mode)
          cslog_pkg::MODE_RECORD: state_nxt = cslog_pkg::ST_IDLE;
          cslog_pkg::MODE_DUMP: begin
            if (!sts.dump_empty) begin
              state_nxt = cslog_pkg::ST_EMIT;
            end else if (sts.out_free) begin
              state_nxt = cslog_pkg::ST_IDLE;
            end
          end
          cslog_pkg::MODE_CLEAR, cslog_pkg::MODE_TOGGLE, cslog_pkg::MODE_STATUS: begin
            if (sts.out_free) begin
              state_nxt = cslog_pkg::ST_IDLE;
            end
          end
          default: state_nxt = cslog_pkg::ST_IDLE;
        endcase
      end
      cslog_pkg::ST_EMIT: begin
        if (sts.out_free && sts.dump_last) begin
          state_nxt = cslog_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cslog_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      cslog_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      cslog_pkg::ST_EXEC: begin
        case (sts.mode)
          cslog_pkg::MODE_RECORD: cmd.do_record = 1'b1;
          cslog_pkg::MODE_DUMP: begin
            cmd.dump_start  = !sts.dump_empty;
            cmd.load_status = sts.dump_empty && sts.out_free;
          end
          cslog_pkg::MODE_CLEAR: begin
            cmd.do_clear    = sts.out_free;
            cmd.load_status = sts.out_free;
          end
          cslog_pkg::MODE_TOGGLE: begin
            cmd.do_toggle   = sts.out_free;
            cmd.load_status = sts.out_free;
          end
          cslog_pkg::MODE_STATUS: cmd.load_status = sts.out_free;
          default: cmd = '0;
        endcase
      end
      cslog_pkg::ST_EMIT: cmd.dump_emit = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== src/cslog_dp.sv =====
module cslog_dp #(
  parameter int unsigned LOG_DEPTH = cslog_pkg::LOG_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cslog_pkg::cmd_t                  cmd,
  output cslog_pkg::sts_t                  sts,
  input  logic [2:0]                       in_tuser,
  input  logic [cslog_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cslog_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                             out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [2:0]                       cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);

  localparam int unsigned ADDR_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(LOG_DEPTH + 1);

  // Configuration register
  logic [5:0] limit_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {26'd0, limit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= cslog_pkg::DUMP_LIMIT_RST;
    end else if (cfg_wr) begin
      limit_r <= cfg_pwdata[5:0];
    end
  end

  // Captured item
  logic [2:0]  mode_r;
  logic [15:0] t_r;
  logic [7:0]  id_r;
  logic [15:0] v_r;
  logic [7:0]  q_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_tuser;
      t_r    <= in_tdata[15:0];
      id_r   <= in_tdata[23:16];
      v_r    <= in_tdata[39:24];
      q_r    <= in_tdata[47:40];
    end
  end

  // Bookkeeping state
  logic              en_r, en_nxt;
  logic [ADDR_W-1:0] slot_r, slot_nxt, slot_inc;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              rec_wr;

  assign rec_wr   = cmd.do_record && en_r;
  assign slot_inc = (slot_r == ADDR_W'(LOG_DEPTH - 1)) ? '0 : slot_r + ADDR_W'(1);

  always_comb begin
    en_nxt   = en_r ^ cmd.do_toggle;
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    if (cmd.do_clear) begin
      slot_nxt = '0;
      cnt_nxt  = '0;
    end else if (rec_wr) begin
      slot_nxt = slot_inc;
      if (cnt_r != CNT_W'(LOG_DEPTH)) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b1;
      slot_r <= '0;
      cnt_r  <= '0;
    end else begin
      en_r   <= en_nxt;
      slot_r <= slot_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Dump length: min(limit clamped to 32, count)
  logic [5:0]        lim6, n_calc, dump_n_r;
  logic [CNT_W+5:0]  cnt_w, lim_w;
  logic [ADDR_W-1:0] idx_r;
  logic [ADDR_W+4:0] idx_w;
  logic [4:0]        idx5;

  assign lim6   = (limit_r > 6'(cslog_pkg::DUMP_MAX)) ? 6'(cslog_pkg::DUMP_MAX) : limit_r;
  assign cnt_w  = (CNT_W + 6)'(cnt_r);
  assign lim_w  = (CNT_W + 6)'(lim6);
  assign n_calc = (cnt_w < lim_w) ? cnt_w[5:0] : lim6;
  assign idx_w  = (ADDR_W + 5)'(idx_r);
  assign idx5   = idx_w[4:0];

  always_ff @(posedge clk) begin
    if (cmd.dump_start) begin
      dump_n_r <= n_calc;
      idx_r    <= '0;
    end else if (cmd.dump_emit) begin
      idx_r <= idx_r + ADDR_W'(1);
    end
  end

  // Record store, single port
  cslog_pkg::log_entry_t mem [LOG_DEPTH];
  cslog_pkg::log_entry_t wr_entry, rd_data_r;
  logic                  mem_rd;
  logic [ADDR_W-1:0]     mem_addr;

  assign mem_rd   = cmd.dump_start || (cmd.dump_emit && !sts.dump_last);
  assign mem_addr = rec_wr ? slot_r : (cmd.dump_start ? '0 : idx_r + ADDR_W'(1));

  always_comb begin
    wr_entry.t   = t_r;
    wr_entry.id  = id_r;
    wr_entry.v   = v_r;
    wr_entry.q   = q_r;
    wr_entry.sum = cslog_pkg::byte_sum(t_r, id_r, v_r, q_r);
  end

  always_ff @(posedge clk) begin
    if (rec_wr) begin
      mem[mem_addr] <= wr_entry;
    end
    if (mem_rd) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  // Output register
  logic                             out_valid_r, out_valid_nxt;
  logic [cslog_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                             out_user_r, out_last_r;
  logic                             rec_ok;
  logic [CNT_W+5:0]                 cnt_nxt_w;
  logic [ADDR_W+4:0]                slot_nxt_w;

  assign rec_ok     = cslog_pkg::byte_sum(rd_data_r.t, rd_data_r.id, rd_data_r.v,
                                          rd_data_r.q) == rd_data_r.sum;
  assign cnt_nxt_w  = (CNT_W + 6)'(cnt_nxt);
  assign slot_nxt_w = (ADDR_W + 5)'(slot_nxt);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_status || cmd.dump_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_status) begin
      out_data_r <= {6'd0, slot_nxt_w[4:0], cnt_nxt_w[5:0], en_nxt, 1'b0,
                     8'd0, 16'd0, 8'd0, 16'd0, 5'd0};
      out_user_r <= 1'b0;
      out_last_r <= 1'b1;
    end else if (cmd.dump_emit) begin
      out_data_r <= {6'd0, slot_nxt_w[4:0], cnt_nxt_w[5:0], en_nxt, rec_ok,
                     rd_data_r.q, rd_data_r.v, rd_data_r.id, rd_data_r.t, idx5};
      out_user_r <= 1'b1;
      out_last_r <= sts.dump_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  assign sts.mode       = mode_r;
  assign sts.dump_empty = (n_calc == 6'd0);
  assign sts.dump_last  = ({1'b0, idx5} == dump_n_r - 6'd1);
  assign sts.out_free   = !out_valid_r || out_tready;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(LOG_DEPTH))
    else $error("count above depth");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r < ADDR_W'(LOG_DEPTH - 1) || slot_r == ADDR_W'(LOG_DEPTH - 1))
    else $error("write slot out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !(cmd.load_status || cmd.dump_emit))
    else $error("pending result overwritten");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dump_emit |-> ({1'b0, idx5} < dump_n_r))
    else $error("dump index past dump length");

  a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
    !(rec_wr && mem_rd))
    else $error("store read and write in one cycle");

endmodule

// ===== src/checksummed_circular_sample_log.sv =====
// Channel  Direction  Handshake          Payload
// in_      input      tvalid/tready      tdata: item fields, tuser: mode
// out_     output     tvalid/tready      tdata: result fields, tuser: is_record, tlast: last
// cfg_     input      APB write/read     dump_limit at byte address 0
//
// Record, clear, toggle and status items pass an accept state, then an execute state.
// A dump adds an emit state for its records; the single-port record store
// is read one slot ahead of the output register.
// Reset (rst_n low, synchronous) clears the bookkeeping and the output valid; the
// store itself is not cleared. A stalled output holds the controller in place;
// a new item is accepted while the last result still waits in the output register.
module checksummed_circular_sample_log #(
  parameter int unsigned LOG_DEPTH = cslog_pkg::LOG_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // time_stamp[15:0], source[23:16], sample[39:24], quality[47:40]
  input  logic [cslog_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode[2:0]
  input  logic [2:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // rec_slot[4:0], rec_time[20:5], rec_sensor[28:21], rec_value[44:29],
  // rec_quality[52:45], rec_ok[53], stat_enabled[54], stat_count[60:55],
  // stat_next[65:61], zero[71:66]
  output logic [cslog_pkg::OUT_DATA_W-1:0] out_tdata,
  // is_record[0]
  output logic                             out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [2:0]                       cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);

  cslog_pkg::cmd_t cmd;
  cslog_pkg::sts_t sts;

  cslog_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cslog_dp #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

endmodule

// ===== dv/checksummed_circular_sample_log_tb.sv =====
module checksummed_circular_sample_log_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = cslog_pkg::LOG_DEPTH_DEF;
  localparam logic [2:0]  LIMIT_ADDR   = 3'd0;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES  = 40;

  typedef struct {
    logic [2:0]  mode;
    logic [15:0] ts;
    logic [7:0]  sensor;
    logic [15:0] value;
    logic [7:0]  qual;
    bit          drain;
  } log_item_t;

  typedef struct {
    logic [15:0] ts;
    logic [7:0]  sensor;
    logic [15:0] value;
    logic [7:0]  qual;
    logic [7:0]  sum;
  } stored_rec_t;

  typedef struct {
    bit          is_rec;
    logic [4:0]  slot;
    logic [15:0] ts;
    logic [7:0]  sensor;
    logic [15:0] value;
    logic [7:0]  qual;
    bit          ok;
    bit          en;
    logic [5:0]  count;
    logic [4:0]  nxt;
    bit          last;
  } log_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // time_stamp[15:0], source[23:16], sample[39:24], quality[47:40]
  logic [cslog_pkg::IN_DATA_W-1:0] in_tdata = '0;
  // mode[2:0]
  logic [2:0] in_tuser = cslog_pkg::MODE_STATUS;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // rec_slot[4:0], rec_time[20:5], rec_sensor[28:21], rec_value[44:29],
  // rec_quality[52:45], rec_ok[53], stat_enabled[54], stat_count[60:55],
  // stat_next[65:61], zero[71:66]
  logic [cslog_pkg::OUT_DATA_W-1:0] out_tdata;
  // is_record[0]
  logic out_tuser;
  logic out_tlast;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  checksummed_circular_sample_log #(.LOG_DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the log state
  stored_rec_t shadow_log [DEPTH];
  logic [4:0]  log_wslot = '0;
  logic [5:0]  log_count = '0;
  bit          log_en = 1'b1;
  logic [5:0]  dump_lim = cslog_pkg::DUMP_LIMIT_RST;

  log_item_t   log_pending[$];
  log_result_t results_due[$];
  log_item_t   cur_item;
  bit          gen_en = 1'b1;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int          drv_gap = 0;
  int          drv_calm = 0;
  int          mon_hold = 0;
  int          mon_calm = 0;

  function automatic logic [7:0] rec_checksum(input logic [47:0] bytes);
    logic [7:0] acc;
    acc = '0;
    for (int k = 0; k < 6; k++) acc += bytes[8*k +: 8];
    return acc;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  function automatic int next_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(20, 40);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 8);
    return $urandom_range(12, 30);
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic push_result(input bit is_rec, input logic [4:0] slot,
                             input stored_rec_t r, input bit last);
    log_result_t e;
    e.is_rec = is_rec;
    e.slot   = slot;
    e.ts     = r.ts;
    e.sensor = r.sensor;
    e.value  = r.value;
    e.qual   = r.qual;
    e.ok     = is_rec && (rec_checksum({r.qual, r.value, r.sensor, r.ts}) == r.sum);
    e.en     = log_en;
    e.count  = log_count;
    e.nxt    = log_wslot;
    e.last   = last;
    results_due.push_back(e);
  endtask

  task automatic log_apply(input log_item_t it);
    stored_rec_t blank;
    int unsigned n;
    blank = '{default: '0};
    case (it.mode)
      cslog_pkg::MODE_RECORD: begin
        if (log_en) begin
          shadow_log[log_wslot] = '{ts: it.ts, sensor: it.sensor, value: it.value,
                                    qual: it.qual,
                                    sum: rec_checksum({it.qual, it.value, it.sensor, it.ts})};
          log_wslot = 5'((log_wslot + 1) % DEPTH);
          if (log_count < DEPTH) log_count++;
        end
      end
      cslog_pkg::MODE_DUMP: begin
        n = (dump_lim > cslog_pkg::DUMP_MAX) ? cslog_pkg::DUMP_MAX : dump_lim;
        if (log_count < n) n = log_count;
        if (n == 0) push_result(1'b0, '0, blank, 1'b1);
        for (int unsigned i = 0; i < n; i++)
          push_result(1'b1, 5'(i), shadow_log[i], i + 1 == n);
      end
      cslog_pkg::MODE_CLEAR: begin
        log_count = '0;
        log_wslot = '0;
        push_result(1'b0, '0, blank, 1'b1);
      end
      cslog_pkg::MODE_TOGGLE: begin
        log_en = !log_en;
        push_result(1'b0, '0, blank, 1'b1);
      end
      cslog_pkg::MODE_STATUS: push_result(1'b0, '0, blank, 1'b1);
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : item_drv
    log_item_t it;
    bit nv;
    if (rst_n) begin
      nv = in_tvalid;
      if (in_tvalid && in_tready) begin
        log_apply(cur_item);
        nv = 1'b0;
      end
      if (!nv) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (log_pending.size() > 0 &&
                     !(log_pending[0].drain && results_due.size() > 0)) begin
          it = log_pending.pop_front();
          cur_item = it;
          in_tuser <= it.mode;
          in_tdata <= {it.qual, it.value, it.sensor, it.ts};
          nv = 1'b1;
          drv_gap = next_gap(drv_calm);
        end
      end
      in_tvalid <= nv;
    end
  end

  always @(posedge clk) begin : result_mon
    log_result_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual tuser=%0b tdata=%h",
                   $time, out_tuser, out_tdata);
          mismatches++;
        end else begin
          e = results_due.pop_front();
          check_field("is_record", e.is_rec, out_tuser);
          check_field("rec_slot", e.slot, out_tdata[4:0]);
          check_field("rec_time", e.ts, out_tdata[20:5]);
          check_field("rec_sensor", e.sensor, out_tdata[28:21]);
          check_field("rec_value", e.value, out_tdata[44:29]);
          check_field("rec_quality", e.qual, out_tdata[52:45]);
          check_field("rec_ok", e.ok, out_tdata[53]);
          check_field("stat_enabled", e.en, out_tdata[54]);
          check_field("stat_count", e.count, out_tdata[60:55]);
          check_field("stat_next", e.nxt, out_tdata[65:61]);
          check_field("last", e.last, out_tlast);
        end
      end
      if (mon_hold > 0) begin
        mon_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        mon_hold = next_gap(mon_calm);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, results_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic add_item(input logic [2:0] mode, input logic [15:0] ts,
                          input logic [7:0] sensor, input logic [15:0] value,
                          input logic [7:0] qual, input bit drain);
    log_item_t it;
    it = '{mode: mode, ts: ts, sensor: sensor, value: value, qual: qual, drain: drain};
    if (mode == cslog_pkg::MODE_TOGGLE) gen_en = !gen_en;
    log_pending.push_back(it);
  endtask

  task automatic add_random(input int n);
    int counted;
    int r;
    logic [2:0] m;
    counted = 0;
    while (counted < n) begin
      r = $urandom_range(0, 99);
      if (r < 62)      m = cslog_pkg::MODE_RECORD;
      else if (r < 78) m = cslog_pkg::MODE_DUMP;
      else if (r < 84) m = cslog_pkg::MODE_STATUS;
      else if (r < 89) m = cslog_pkg::MODE_TOGGLE;
      else if (r < 92) m = cslog_pkg::MODE_CLEAR;
      else if (r < 95) m = cslog_pkg::MODE_STATUS + 3'($urandom_range(1, 3));
      else             m = cslog_pkg::MODE_RECORD;
      // ignored items do not count toward the total
      if (m <= cslog_pkg::MODE_STATUS && !(m == cslog_pkg::MODE_RECORD && !gen_en))
        counted++;
      add_item(m, 16'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
               $urandom_range(0, 39) == 0);
    end
  endtask

  // Enable logging, then write enough records to wrap and saturate, then dump.
  task automatic fill_log(input int n);
    if (!gen_en) add_item(cslog_pkg::MODE_TOGGLE, '0, '0, '0, '0, 1'b0);
    repeat (n)
      add_item(cslog_pkg::MODE_RECORD, 16'($urandom), 8'($urandom), 16'($urandom),
               8'($urandom), 1'b0);
    add_item(cslog_pkg::MODE_DUMP, '0, '0, '0, '0, 1'b0);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (log_pending.size() > 0 || in_tvalid || results_due.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_xfer(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_dump_limit(input logic [5:0] lim);
    logic [31:0] rd;
    apb_xfer(1'b1, LIMIT_ADDR, {26'd0, lim}, rd);
    dump_lim = lim;
    apb_xfer(1'b0, LIMIT_ADDR, '0, rd);
    check_field("dump_limit readback", lim, rd);
  endtask

  initial begin
    logic [31:0] rd;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    apb_xfer(1'b0, LIMIT_ADDR, '0, rd);
    check_field("dump_limit reset", cslog_pkg::DUMP_LIMIT_RST, rd);

    add_item(cslog_pkg::MODE_STATUS, '0, '0, '0, '0, 1'b0);
    add_item(cslog_pkg::MODE_DUMP, '0, '0, '0, '0, 1'b0);        // empty log
    add_item(cslog_pkg::MODE_STATUS + 3'd1, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 1'b0);
    add_item(cslog_pkg::MODE_RECORD, 16'h0000, 8'h00, 16'h0000, 8'h00, 1'b0);
    add_item(cslog_pkg::MODE_RECORD, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 1'b0);
    add_item(cslog_pkg::MODE_RECORD, 16'hA5A5, 8'h5A, 16'h5A5A, 8'hA5, 1'b0);
    add_item(cslog_pkg::MODE_RECORD, 16'h0001, 8'h80, 16'h8000, 8'h01, 1'b0);
    add_item(cslog_pkg::MODE_DUMP, '0, '0, '0, '0, 1'b0);
    add_item(cslog_pkg::MODE_TOGGLE, '0, '0, '0, '0, 1'b0);
    // dropped, logging disabled
    add_item(cslog_pkg::MODE_RECORD, 16'h1234, 8'h56, 16'h789A, 8'hBC, 1'b0);
    add_item(cslog_pkg::MODE_STATUS, '0, '0, '0, '0, 1'b0);
    add_item(cslog_pkg::MODE_DUMP, '0, '0, '0, '0, 1'b0);
    add_item(cslog_pkg::MODE_TOGGLE, '0, '0, '0, '0, 1'b0);
    add_item(cslog_pkg::MODE_STATUS + 3'd2, 16'h5555, 8'hAA, 16'hAAAA, 8'h55, 1'b0);
    add_item(cslog_pkg::MODE_STATUS + 3'd3, 16'h0F0F, 8'hF0, 16'hF0F0, 8'h0F, 1'b0);
    add_item(cslog_pkg::MODE_CLEAR, '0, '0, '0, '0, 1'b0);
    add_item(cslog_pkg::MODE_DUMP, '0, '0, '0, '0, 1'b0);
    add_item(cslog_pkg::MODE_RECORD, 16'hFF00, 8'h7F, 16'h00FF, 8'hFE, 1'b0);
    add_item(cslog_pkg::MODE_DUMP, '0, '0, '0, '0, 1'b1);        // hold until drained
    add_item(cslog_pkg::MODE_STATUS, '0, '0, '0, '0, 1'b0);
    add_random(14);
    wait_idle();

    set_dump_limit(6'd32);
    fill_log(36);
    add_random(14);
    wait_idle();

    set_dump_limit(6'd1);
    add_random(8);
    wait_idle();

    set_dump_limit(6'd0);
    add_random(8);
    wait_idle();

    set_dump_limit(6'd63);
    fill_log(33);
    add_random(8);
    wait_idle();

    set_dump_limit(6'd33);
    add_random(8);
    wait_idle();

    set_dump_limit(6'($urandom_range(2, 31)));
    add_random(10);
    wait_idle();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
